// ----- rtl/dcts_pkg.sv -----
// Types and constants shared by the chain tag sequencer files.
package dcts_pkg;

  // Field widths.
  localparam int unsigned AddrW  = 32;
  localparam int unsigned QwcW   = 16;
  localparam int unsigned TagIdW = 3;
  localparam int unsigned DepthW = 2;

  // A quadword is sixteen bytes, and every tag is one quadword long.
  localparam int unsigned   QwShift = 4;
  localparam logic [AddrW-1:0] TagBytes = AddrW'(16);

  // Operation codes.
  typedef enum logic {
    OpLoad = 1'b0,
    OpTag  = 1'b1
  } op_e;

  // Tag identifiers.
  typedef enum logic [TagIdW-1:0] {
    TagRefe = 3'd0,
    TagCnt  = 3'd1,
    TagNext = 3'd2,
    TagRef  = 3'd3,
    TagRefs = 3'd4,
    TagCall = 3'd5,
    TagRet  = 3'd6,
    TagEnd  = 3'd7
  } tag_id_e;

  // Stack depth codes.
  localparam logic [DepthW-1:0] DepthEmpty = 2'd0;
  localparam logic [DepthW-1:0] DepthOne   = 2'd1;
  localparam logic [DepthW-1:0] DepthFull  = 2'd2;

  // One request as held in the input register.
  typedef struct packed {
    op_e              operation;
    logic [AddrW-1:0] start_address;
    tag_id_e          tag_id;
    logic [AddrW-1:0] tag_address_field;
    logic [QwcW-1:0]  tag_quadwords;
  } req_t;

  // Architectural state of the sequencer.
  typedef struct packed {
    logic [AddrW-1:0]  tag_addr;
    logic [AddrW-1:0]  mem_addr;
    logic [AddrW-1:0]  ret_addr_0;
    logic [AddrW-1:0]  ret_addr_1;
    logic [DepthW-1:0] depth;
  } state_t;

  // One result.
  typedef struct packed {
    logic [AddrW-1:0]  next_tag_address;
    logic [AddrW-1:0]  data_address;
    logic              end_transfer;
    logic              stack_overflow;
    logic              null_call;
    logic [DepthW-1:0] stack_depth;
  } rsp_t;

endpackage

// ----- rtl/dcts_if.sv -----
// Valid/ready channel interfaces for requests and results.
interface dcts_req_if;
  import dcts_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [AddrW-1:0]   start_address;
  logic [TagIdW-1:0]  tag_id;
  logic [AddrW-1:0]   tag_address_field;
  logic [QwcW-1:0]    tag_quadwords;

  modport source (
    output valid, operation, start_address, tag_id, tag_address_field, tag_quadwords,
    input  ready
  );
  modport sink (
    input  valid, operation, start_address, tag_id, tag_address_field, tag_quadwords,
    output ready
  );
endinterface

interface dcts_rsp_if;
  import dcts_pkg::*;

  logic               valid;
  logic               ready;
  logic [AddrW-1:0]   next_tag_address;
  logic [AddrW-1:0]   data_address;
  logic               end_transfer;
  logic               stack_overflow;
  logic               null_call;
  logic [DepthW-1:0]  stack_depth;

  modport source (
    output valid, next_tag_address, data_address, end_transfer, stack_overflow,
           null_call, stack_depth,
    input  ready
  );
  modport sink (
    input  valid, next_tag_address, data_address, end_transfer, stack_overflow,
           null_call, stack_depth,
    output ready
  );
endinterface

// ----- rtl/dcts_step.sv -----
// Next-state and result logic for one request of the chain tag sequencer.
module dcts_step (
  input  dcts_pkg::req_t   req_i,
  input  dcts_pkg::state_t state_i,
  output dcts_pkg::state_t state_o,
  output dcts_pkg::rsp_t   rsp_o
);
  import dcts_pkg::*;

  logic [AddrW-1:0] after_tag;
  logic [AddrW-1:0] call_ret;
  logic             end_flag;
  logic             ovf_flag;
  logic             nul_flag;
  state_t           nxt;

  // Address of the quadword after the current tag, and past the tag's data.
  assign after_tag = state_i.tag_addr + TagBytes;
  assign call_ret  = after_tag + (AddrW'(req_i.tag_quadwords) << QwShift);

  // Tag rules.
  always_comb begin
    nxt      = state_i;
    end_flag = 1'b0;
    ovf_flag = 1'b0;
    nul_flag = 1'b0;
    if (req_i.operation == OpLoad) begin
      nxt.tag_addr   = req_i.start_address;
      nxt.depth      = DepthEmpty;
      nxt.ret_addr_0 = '0;
      nxt.ret_addr_1 = '0;
    end else begin
      nxt.mem_addr = req_i.tag_address_field;
      unique case (req_i.tag_id)
        TagRefe: begin
          nxt.tag_addr = after_tag;
          end_flag     = 1'b1;
        end
        TagCnt: begin
          nxt.tag_addr = after_tag;
          nxt.mem_addr = after_tag;
        end
        TagNext: begin
          nxt.mem_addr = after_tag;
          nxt.tag_addr = req_i.tag_address_field;
        end
        TagRef, TagRefs: begin
          nxt.tag_addr = after_tag;
        end
        TagCall: begin
          nxt.mem_addr = after_tag;
          // A zero target skips the data; else push, or overflow when full.
          priority if (req_i.tag_address_field == '0) begin
            nxt.tag_addr = call_ret;
            nul_flag     = 1'b1;
          end else if (state_i.depth == DepthEmpty) begin
            nxt.ret_addr_0 = call_ret;
            nxt.depth      = DepthOne;
            nxt.tag_addr   = req_i.tag_address_field;
          end else if (state_i.depth == DepthOne) begin
            nxt.ret_addr_1 = call_ret;
            nxt.depth      = DepthFull;
            nxt.tag_addr   = req_i.tag_address_field;
          end else begin
            ovf_flag = 1'b1;
            end_flag = 1'b1;
          end
        end
        TagRet: begin
          nxt.mem_addr = after_tag;
          // Pop the top entry and clear it; an empty stack ends the chain.
          priority if (state_i.depth == DepthFull) begin
            nxt.tag_addr   = state_i.ret_addr_1;
            nxt.ret_addr_1 = '0;
            nxt.depth      = DepthOne;
          end else if (state_i.depth == DepthOne) begin
            nxt.tag_addr   = state_i.ret_addr_0;
            nxt.ret_addr_0 = '0;
            nxt.depth      = DepthEmpty;
          end else begin
            end_flag = 1'b1;
          end
        end
        TagEnd: begin
          nxt.mem_addr = after_tag;
          end_flag     = 1'b1;
        end
        default: begin
          end_flag = 1'b1;
        end
      endcase
    end
  end

  assign state_o = nxt;

  // Result fields.
  assign rsp_o.next_tag_address = nxt.tag_addr;
  assign rsp_o.data_address     = nxt.mem_addr;
  assign rsp_o.end_transfer     = end_flag;
  assign rsp_o.stack_overflow   = ovf_flag;
  assign rsp_o.null_call        = nul_flag;
  assign rsp_o.stack_depth      = nxt.depth;

endmodule

// ----- rtl/dma_chain_tag_step_with_stack.sv -----
// Top level of the source-chain DMA tag sequencer with a two-entry call stack.
//
//   channel  direction  contents
//   req_i    in         operation, start_address, tag_id, tag_address_field, tag_quadwords
//   rsp_o    out        next_tag_address, data_address, end_transfer, stack_overflow,
//                       null_call, stack_depth
//
// Each request is held first in the input register and then in the result register,
// which drives its result. A new request is accepted every cycle while no result stalls.
// The tag and stack registers update when a request leaves the input register, so the
// next request sees them at once. A stalled result holds the result register and, once
// the input register is full too, drops req_i.ready. Reset empties both registers and
// clears all tag, address and stack state.
module dma_chain_tag_step_with_stack (
  input  logic       clk_i,
  input  logic       rst_ni,
  dcts_req_if.sink   req_i,
  dcts_rsp_if.source rsp_o
);
  import dcts_pkg::*;

  logic   in_valid_q;
  req_t   in_req_q;
  req_t   in_req_d;
  logic   out_valid_q;
  rsp_t   out_rsp_q;
  rsp_t   step_rsp;
  state_t state_q;
  state_t state_d;
  logic   out_free;
  logic   advance;

  // Handshake control.
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign advance     = in_valid_q && out_free;
  assign req_i.ready = !in_valid_q || out_free;

  // Gather the request fields.
  assign in_req_d.operation         = op_e'(req_i.operation);
  assign in_req_d.start_address     = req_i.start_address;
  assign in_req_d.tag_id            = tag_id_e'(req_i.tag_id);
  assign in_req_d.tag_address_field = req_i.tag_address_field;
  assign in_req_d.tag_quadwords     = req_i.tag_quadwords;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_req_q <= in_req_d;
    end
  end

  // Tag rule logic.
  dcts_step u_step (
    .req_i   (in_req_q),
    .state_i (state_q),
    .state_o (state_d),
    .rsp_o   (step_rsp)
  );

  // Sequencer state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rsp_q <= step_rsp;
    end
  end

  // Result port.
  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.next_tag_address = out_rsp_q.next_tag_address;
  assign rsp_o.data_address     = out_rsp_q.data_address;
  assign rsp_o.end_transfer     = out_rsp_q.end_transfer;
  assign rsp_o.stack_overflow   = out_rsp_q.stack_overflow;
  assign rsp_o.null_call        = out_rsp_q.null_call;
  assign rsp_o.stack_depth      = out_rsp_q.stack_depth;

endmodule

// ----- tb/sv/tag_step_checker.sv -----
// Checker that predicts and compares the results of the chain tag sequencer.
module tag_step_checker (
  input  logic clk_i,
  input  logic rst_ni,
  dcts_req_if  req_i,
  dcts_rsp_if  rsp_i,
  output int   pending_o,
  output int   fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import dcts_pkg::*;

  // Predicted copy of the sequencer's tag, address and stack registers.
  logic [AddrW-1:0]  tag_addr;
  logic [AddrW-1:0]  mem_addr;
  logic [AddrW-1:0]  ret_addr_0;
  logic [AddrW-1:0]  ret_addr_1;
  logic [DepthW-1:0] depth;

  rsp_t predicted_steps[$];
  int   mismatches;

  // Applies one request to the predicted state and returns the result it gives.
  function automatic rsp_t advance_chain(req_t rq);
    rsp_t             res;
    logic [AddrW-1:0] after;
    logic [AddrW-1:0] resume;
    res = '0;
    if (rq.operation == OpLoad) begin
      tag_addr   = rq.start_address;
      depth      = DepthEmpty;
      ret_addr_0 = '0;
      ret_addr_1 = '0;
    end else begin
      after    = tag_addr + TagBytes;
      resume   = AddrW'(rq.tag_quadwords);
      resume   = after + (resume << QwShift);
      mem_addr = rq.tag_address_field;
      case (rq.tag_id)
        TagRefe: begin
          tag_addr = after;
          res.end_transfer = 1'b1;
        end
        TagCnt: begin
          tag_addr = after;
          mem_addr = after;
        end
        TagNext: begin
          mem_addr = after;
          tag_addr = rq.tag_address_field;
        end
        TagRef, TagRefs: begin
          tag_addr = after;
        end
        TagCall: begin
          mem_addr = after;
          // A zero target skips the data; otherwise push if there is room.
          if (rq.tag_address_field == '0) begin
            tag_addr = resume;
            res.null_call = 1'b1;
          end else if (depth == DepthEmpty) begin
            ret_addr_0 = resume;
            depth      = DepthOne;
            tag_addr   = rq.tag_address_field;
          end else if (depth == DepthOne) begin
            ret_addr_1 = resume;
            depth      = DepthFull;
            tag_addr   = rq.tag_address_field;
          end else begin
            res.stack_overflow = 1'b1;
            res.end_transfer   = 1'b1;
          end
        end
        TagRet: begin
          mem_addr = after;
          // Pop the newest return address; an empty stack ends the chain.
          if (depth == DepthFull) begin
            tag_addr   = ret_addr_1;
            ret_addr_1 = '0;
            depth      = DepthOne;
          end else if (depth == DepthOne) begin
            tag_addr   = ret_addr_0;
            ret_addr_0 = '0;
            depth      = DepthEmpty;
          end else begin
            res.end_transfer = 1'b1;
          end
        end
        default: begin
          mem_addr = after;
          res.end_transfer = 1'b1;
        end
      endcase
    end
    res.next_tag_address = tag_addr;
    res.data_address     = mem_addr;
    res.stack_depth      = depth;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [AddrW-1:0] want,
                             input logic [AddrW-1:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare results first: a request never gets its result at the edge it is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    req_t rq;
    rsp_t want;
    if (!rst_ni) begin
      tag_addr   = '0;
      mem_addr   = '0;
      ret_addr_0 = '0;
      ret_addr_1 = '0;
      depth      = DepthEmpty;
      mismatches = 0;
      predicted_steps.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        if (predicted_steps.size() == 0) begin
          $error("result with no request waiting: tag 0x%08h data 0x%08h",
                 rsp_i.next_tag_address, rsp_i.data_address);
          mismatches++;
        end else begin
          want = predicted_steps.pop_front();
          check_field("next_tag_address", want.next_tag_address, rsp_i.next_tag_address);
          check_field("data_address", want.data_address, rsp_i.data_address);
          check_field("end_transfer", AddrW'(want.end_transfer),
                      AddrW'(rsp_i.end_transfer));
          check_field("stack_overflow", AddrW'(want.stack_overflow),
                      AddrW'(rsp_i.stack_overflow));
          check_field("null_call", AddrW'(want.null_call), AddrW'(rsp_i.null_call));
          check_field("stack_depth", AddrW'(want.stack_depth), AddrW'(rsp_i.stack_depth));
        end
      end
      if (req_i.valid && req_i.ready) begin
        rq.operation         = op_e'(req_i.operation);
        rq.start_address     = req_i.start_address;
        rq.tag_id            = tag_id_e'(req_i.tag_id);
        rq.tag_address_field = req_i.tag_address_field;
        rq.tag_quadwords     = req_i.tag_quadwords;
        predicted_steps.push_back(advance_chain(rq));
      end
      pending_o    <= predicted_steps.size();
      fail_count_o <= mismatches;
    end
  end

endmodule

// ----- tb/sv/tb_dma_chain_tag_step_with_stack.sv -----
// Testbench top: clock, reset, request stimulus, result back-pressure and verdict.
module tb_dma_chain_tag_step_with_stack;
  timeunit 1ns;
  timeprecision 1ps;
  import dcts_pkg::*;

  localparam int unsigned PhaseRequests = 250;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   pending_steps;
  int   fail_count;
  int   requests_sent = 0;
  int   req_idle_pct  = 0;
  int   rsp_stall_pct = 0;

  dcts_req_if req_if ();
  dcts_rsp_if rsp_if ();

  dma_chain_tag_step_with_stack i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  tag_step_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_i       (rsp_if),
    .pending_o   (pending_steps),
    .fail_count_o(fail_count)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Result back-pressure at the rate of the current phase.
  always @(posedge clk_i) begin
    rsp_if.ready <= rst_ni && ($urandom_range(99) >= rsp_stall_pct);
  end

  // Hard limit on the run time.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [AddrW-1:0] rand_addr();
    case ($urandom_range(7))
      0: return '0;
      1: return {AddrW{1'b1}} - AddrW'($urandom_range(63));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [QwcW-1:0] rand_qwc();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      2: return QwcW'($urandom_range(15));
      default: return QwcW'($urandom);
    endcase
  endfunction

  // Offers one request after a random idle gap and waits until it is taken.
  task automatic send_request(input op_e op, input logic [AddrW-1:0] start,
                              input tag_id_e id, input logic [AddrW-1:0] field,
                              input logic [QwcW-1:0] qwc);
    while ($urandom_range(99) < req_idle_pct) begin
      req_if.valid             <= 1'b0;
      req_if.operation         <= 1'($urandom_range(1));
      req_if.start_address     <= $urandom;
      req_if.tag_id            <= TagIdW'($urandom_range(7));
      req_if.tag_address_field <= $urandom;
      req_if.tag_quadwords     <= QwcW'($urandom_range(65535));
      @(posedge clk_i);
    end
    req_if.valid             <= 1'b1;
    req_if.operation         <= op;
    req_if.start_address     <= start;
    req_if.tag_id            <= id;
    req_if.tag_address_field <= field;
    req_if.tag_quadwords     <= qwc;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    requests_sent++;
  endtask

  // Holds off the sender until every predicted result has come back.
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_steps != 0) @(posedge clk_i);
  endtask

  // One chain: a load, a run of tags with random content, then usually a terminator.
  task automatic send_chain();
    int      len;
    int      pick;
    tag_id_e id;
    len = $urandom_range(3, 12);
    send_request(OpLoad, rand_addr(), tag_id_e'($urandom_range(7)), $urandom, rand_qwc());
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 12)      id = TagCnt;
      else if (pick < 22) id = TagNext;
      else if (pick < 30) id = TagRef;
      else if (pick < 38) id = TagRefs;
      else if (pick < 66) id = TagCall;
      else if (pick < 90) id = TagRet;
      else if (pick < 95) id = TagRefe;
      else                id = TagEnd;
      send_request(OpTag, $urandom, id, rand_addr(), rand_qwc());
    end
    if ($urandom_range(3) != 0) begin
      send_request(OpTag, $urandom, $urandom_range(1) ? TagEnd : TagRefe, rand_addr(),
                   rand_qwc());
    end
  endtask

  // Random traffic until the phase has sent its share of requests.
  task automatic run_random_phase();
    int goal;
    goal = requests_sent + PhaseRequests;
    while (requests_sent < goal) begin
      if ($urandom_range(9) < 8) begin
        send_chain();
      end else begin
        send_request(op_e'($urandom_range(1)), $urandom, tag_id_e'($urandom_range(7)),
                     $urandom, QwcW'($urandom));
      end
    end
  endtask

  initial begin
    rst_ni                   = 1'b0;
    req_if.valid             = 1'b0;
    req_if.operation         = OpLoad;
    req_if.start_address     = '0;
    req_if.tag_id            = TagRefe;
    req_if.tag_address_field = '0;
    req_if.tag_quadwords     = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    req_idle_pct  = 23;
    rsp_stall_pct = 50;

    // Address wrap on cnt, then a refe, with ignored load fields all ones.
    send_request(OpLoad, 32'hFFFF_FFF0, TagEnd, '1, '1);
    send_request(OpTag, '1, TagCnt, 32'h0000_0040, '1);
    send_request(OpTag, '0, TagRefe, '1, '1);
    // Next to the top address, then end wrapping the data address.
    send_request(OpLoad, '0, TagRefe, '0, '0);
    send_request(OpTag, '0, TagNext, '1, 16'h0001);
    send_request(OpTag, '0, TagEnd, 32'h1234_5678, '0);
    send_request(OpTag, '0, TagRef, 32'h1234_5670, 16'h0100);
    send_request(OpTag, '0, TagRefs, '0, 16'h8000);
    // Fill the stack, overflow it, try a null call on a full stack, then unwind.
    send_request(OpLoad, 32'h0000_1000, TagCall, '0, '0);
    send_request(OpTag, '0, TagCall, 32'h0000_2000, '1);
    send_request(OpTag, '0, TagCall, 32'h0000_3000, '0);
    send_request(OpTag, '0, TagCall, 32'h0000_4000, 16'h0001);
    send_request(OpTag, '0, TagCall, '0, '1);
    send_request(OpTag, '0, TagRet, '1, '1);
    send_request(OpTag, '0, TagRet, '0, '0);
    send_request(OpTag, '0, TagRet, 32'h0000_5555, 16'h5555);
    // A load clears a full stack; then an empty return, a null call near the top, a call and a return.
    send_request(OpTag, '0, TagCall, 32'h0000_5000, 16'h0002);
    send_request(OpTag, '0, TagCall, 32'h0000_6000, 16'h0003);
    send_request(OpLoad, '1, TagRet, '1, '1);
    send_request(OpTag, '0, TagRet, '0, '0);
    send_request(OpTag, '0, TagCall, '0, '0);
    send_request(OpTag, '0, TagCall, '1, '1);
    send_request(OpTag, '0, TagRet, '0, '0);

    run_random_phase();
    drain_results();

    req_idle_pct  = 50;
    rsp_stall_pct = 23;
    run_random_phase();
    drain_results();

    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    run_random_phase();
    drain_results();
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/dcts_pkg.sv
rtl/dcts_if.sv
rtl/dcts_step.sv
rtl/dma_chain_tag_step_with_stack.sv
tb/sv/tag_step_checker.sv
tb/sv/tb_dma_chain_tag_step_with_stack.sv
